FILE: sv/kaest_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the Kalman ARX estimator.
// No dependencies; every other file but kaest_ram imports this package.
package kaest_pkg;

    localparam int Q_W        = 32;
    localparam int RND_W      = 40;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int DIV_W      = 56;
    localparam int DEF_OUTPUT_ORDER = 2;
    localparam int DEF_INPUT_ORDER  = 2;

    localparam logic signed [Q_W-1:0] P_INIT = 32'sd1678;
    localparam logic [CFG_DATA_W-1:0] RV_RESET = 31'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RV = 3'd0,
        REG_Q0 = 3'd1,
        REG_Q1 = 3'd2,
        REG_Q2 = 3'd3,
        REG_Q3 = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] plant_output;
        logic signed [Q_W-1:0] plant_input;
    } in_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] estimate_a1;
        logic signed [Q_W-1:0] estimate_a2;
        logic signed [Q_W-1:0] estimate_b1;
        logic signed [Q_W-1:0] estimate_b2;
    } out_item_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } mac_ctl_t;

    function automatic logic signed [ACC_W-1:0] sx32(input logic signed [Q_W-1:0] v);
        return {{(ACC_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] sx40(input logic signed [RND_W-1:0] v);
        return {{(ACC_W-RND_W){v[RND_W-1]}}, v};
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = sx32(32'sh7FFF_FFFF);
        lo = sx32(32'sh8000_0000);
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] theta_init(input int i);
        logic signed [Q_W-1:0] r;
        r = '0;
        unique case (i)
            0:       r = -32'sd6710886;
            1:       r = -32'sd8388608;
            2:       r = 32'sd33554;
            3:       r = 32'sd16777;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/kaest_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kaest_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/kaest_mac.sv
`timescale 1ns / 1ps
// Shared Q8.24 multiplier with round-half-up and a wide accumulator.
// Depends on kaest_pkg.
module kaest_mac
    import kaest_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic signed [Q_W-1:0]   a,
    input  logic signed [Q_W-1:0]   b,
    output logic signed [RND_W-1:0] rnd,
    output logic signed [ACC_W-1:0] acc_sum
);

    logic signed [2*Q_W-1:0] prod_reg;
    logic signed [2*Q_W-1:0] biased;
    logic signed [ACC_W-1:0] acc_reg;

    // The product is registered before it is rounded and summed.
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= a * b;
        end
    end

    assign biased  = prod_reg + 64'sd8388608;
    assign rnd     = biased[2*Q_W-1:24];
    assign acc_sum = acc_reg + sx40(rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            acc_reg <= acc_sum;
        end
    end

endmodule

FILE: sv/kaest_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider forming round(num * 2^24 / den), saturated.
// Depends on kaest_pkg.
module kaest_div
    import kaest_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [Q_W-1:0] num,
    input  logic [Q_W-1:0]        den,
    output logic                  done,
    output logic signed [Q_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [Q_W-1:0]    den_reg;
    logic [Q_W-1:0]    rem_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic signed [Q_W-1:0] quot_reg;
    logic [Q_W-1:0]    mag;
    logic [Q_W:0]      shl;
    logic              fit;

    assign mag  = num[Q_W-1] ? Q_W'(-num) : Q_W'(num);
    assign shl  = {rem_reg, dvd_reg[DIV_W-1]};
    assign fit  = shl >= {1'b0, den_reg};
    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DIV_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[Q_W-1];
            den_reg <= den;
            rem_reg <= '0;
            // Half the divisor is added first so that truncation rounds to nearest.
            dvd_reg <= {mag, 24'b0} + DIV_W'(den >> 1);
        end
        else if (busy_reg && cnt_reg != CNT_W'(DIV_W))
        begin
            rem_reg <= fit ? Q_W'(shl - {1'b0, den_reg}) : shl[Q_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], fit};
        end
        else if (busy_reg)
        begin
            if (|dvd_reg[DIV_W-1:Q_W-1])
            begin
                quot_reg <= neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            else
            begin
                quot_reg <= neg_reg ? -signed'(dvd_reg[Q_W-1:0]) : signed'(dvd_reg[Q_W-1:0]);
            end
        end
    end

endmodule

FILE: sv/kalman_arx_parameter_estimator_core.sv
`timescale 1ns / 1ps
// Kalman ARX parameter estimator: one request in, one set of four estimates out.
// Each request is worked through on one shared multiplier, with a bit-serial
// divider for the gains; the next request is taken only once the core is idle.
// Asynchronous active-low reset restores covariance, estimates and regressor.
module kalman_arx_parameter_estimator_core
    import kaest_pkg::*;
#(
    parameter int OUTPUT_ORDER = DEF_OUTPUT_ORDER,
    parameter int INPUT_ORDER  = DEF_INPUT_ORDER
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int N_THETA = OUTPUT_ORDER + INPUT_ORDER;
    localparam int N_P     = N_THETA * N_THETA;
    localparam int IW      = $clog2(N_THETA);
    localparam int AW      = $clog2(N_P);
    localparam int NZ_CNT  = (N_THETA < 4) ? N_THETA : 4;
    localparam logic [IW-1:0] LAST    = IW'(N_THETA - 1);
    localparam logic [IW-1:0] NZ_LAST = IW'(NZ_CNT - 1);

    // The sequencer walks one dot product or element update at a time. Each
    // product passes through covariance read, multiply, then round and add.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NZ_RD,
        ST_NZ_WR,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // Work phases in model order: P*x, x'Px, x'theta, theta update, x'P, P update.
    typedef enum logic [2:0] {
        PH_PX,
        PH_XPX,
        PH_XT,
        PH_TH,
        PH_XP,
        PH_PU
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;
    logic [IW-1:0] o_reg;
    logic [IW-1:0] n_reg;
    logic [AW-1:0] addr_reg;
    logic          diag_reg;
    logic [N_P-1:0] pvalid_reg;

    logic [CFG_DATA_W-1:0] rv_reg;
    logic [CFG_DATA_W-1:0] q_reg [4];

    logic signed [Q_W-1:0] theta_reg [N_THETA];
    logic signed [Q_W-1:0] x_reg     [N_THETA];
    logic signed [Q_W-1:0] px_reg    [N_THETA];
    logic signed [Q_W-1:0] xp_reg    [N_THETA];
    logic signed [Q_W-1:0] gain_reg  [N_THETA];
    logic signed [Q_W-1:0] y_reg;
    logic signed [Q_W-1:0] u_reg;
    logic signed [Q_W-1:0] innov_reg;
    logic signed [Q_W-1:0] p_hold_reg;
    logic signed [Q_W+1:0] den_reg;

    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    // Covariance store and the shared units.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [Q_W-1:0]        ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [Q_W-1:0]        ram_rdata;
    logic signed [Q_W-1:0] p_eff;

    mac_ctl_t              mac_ctl;
    logic signed [Q_W-1:0] mac_a;
    logic signed [Q_W-1:0] mac_b;
    logic signed [RND_W-1:0] mac_rnd;
    logic signed [ACC_W-1:0] mac_sum;
    logic signed [Q_W-1:0] dot_sat;

    logic                  div_start;
    logic                  div_done;
    logic signed [Q_W-1:0] div_quot;
    logic                  den_pos;

    logic [IW-1:0]         row_c;
    logic [IW-1:0]         col_c;
    logic [AW-1:0]         addr_c;
    logic signed [Q_W-1:0] est_c [4];

    kaest_ram #(
        .WIDTH (Q_W),
        .DEPTH (N_P)
    ) u_cov_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kaest_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .a       (mac_a),
        .b       (mac_b),
        .rnd     (mac_rnd),
        .acc_sum (mac_sum)
    );

    kaest_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (px_reg[n_reg]),
        .den   (den_reg[Q_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Covariance entries never written since reset read as their reset value,
    // which is the initial variance on the diagonal and zero elsewhere.
    assign p_eff = pvalid_reg[addr_reg] ? signed'(ram_rdata) : (diag_reg ? P_INIT : '0);

    // Element addressing: P*x walks a row, x'P and the P update walk a column.
    always_comb
    begin
        row_c = n_reg;
        col_c = o_reg;
        if (state_reg == ST_NZ_RD)
        begin
            col_c = n_reg;
        end
        else if (phase_reg == PH_PX)
        begin
            row_c = o_reg;
            col_c = n_reg;
        end
    end

    assign addr_c    = AW'(row_c) + AW'(AW'(col_c) * AW'(N_THETA));
    assign ram_raddr = addr_c;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mac_a = x_reg[n_reg];
        mac_b = p_eff;
        unique case (phase_reg)
            PH_PX:
            begin
                mac_a = p_eff;
                mac_b = x_reg[n_reg];
            end
            PH_XPX:  mac_b = px_reg[n_reg];
            PH_XT:   mac_b = theta_reg[n_reg];
            PH_TH:
            begin
                mac_a = gain_reg[n_reg];
                mac_b = innov_reg;
            end
            PH_XP:   mac_b = p_eff;
            PH_PU:
            begin
                mac_a = gain_reg[n_reg];
                mac_b = xp_reg[o_reg];
            end
            default: mac_b = p_eff;
        endcase
    end

    assign dot_sat = sat32(mac_sum);
    assign den_pos = !den_reg[Q_W+1] && (den_reg != '0);

    always_comb
    begin
        mac_ctl.mul_en  = (state_reg == ST_MUL);
        mac_ctl.acc_en  = (state_reg == ST_ACC) && (phase_reg != PH_TH) && (phase_reg != PH_PU);
        mac_ctl.acc_clr = (state_reg == ST_ACC) && (n_reg == LAST);
        div_start       = (state_reg == ST_DIV_GO) && den_pos;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = p_eff;
        if (state_reg == ST_NZ_WR)
        begin
            ram_we    = 1'b1;
            ram_wdata = sat32(sx32(p_eff) + ACC_W'(q_reg[2'(n_reg)]));
        end
        else if (state_reg == ST_ACC && phase_reg == PH_PU)
        begin
            ram_we    = 1'b1;
            ram_wdata = sat32(sx32(p_hold_reg) - sx40(mac_rnd));
        end
    end

    // Result fields with no estimate behind them read as zero.
    for (genvar g = 0; g < 4; g++)
    begin : g_est
        if (g < N_THETA)
        begin : g_live
            assign est_c[g] = theta_reg[g];
        end
        else
        begin : g_zero
            assign est_c[g] = '0;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers; writes to unknown indices are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= RV_RESET;
            for (int k = 0; k < 4; k++)
            begin
                q_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RV:  rv_reg   <= cfg_data;
                REG_Q0:  q_reg[0] <= cfg_data;
                REG_Q1:  q_reg[1] <= cfg_data;
                REG_Q2:  q_reg[2] <= cfg_data;
                REG_Q3:  q_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer with its working registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PX;
            o_reg         <= '0;
            n_reg         <= '0;
            pvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < N_THETA; k++)
            begin
                theta_reg[k] <= theta_init(k);
                x_reg[k]     <= '0;
            end
        end
        else
        begin
            // In the output state the new result replaces a departing one below.
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                pvalid_reg[addr_reg] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        y_reg     <= in_data.plant_output;
                        u_reg     <= in_data.plant_input;
                        n_reg     <= '0;
                        o_reg     <= '0;
                        state_reg <= ST_NZ_RD;
                    end
                end

                ST_NZ_RD:
                begin
                    addr_reg  <= addr_c;
                    diag_reg  <= 1'b1;
                    state_reg <= ST_NZ_WR;
                end

                ST_NZ_WR:
                begin
                    if (n_reg == NZ_LAST)
                    begin
                        n_reg     <= '0;
                        phase_reg <= PH_PX;
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= ST_NZ_RD;
                    end
                end

                ST_RD:
                begin
                    addr_reg  <= addr_c;
                    diag_reg  <= (row_c == col_c);
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    p_hold_reg <= p_eff;
                    state_reg  <= ST_ACC;
                end

                ST_ACC:
                begin
                    if (phase_reg == PH_TH)
                    begin
                        theta_reg[n_reg] <= sat32(sx32(theta_reg[n_reg]) + sx40(mac_rnd));
                    end
                    if (n_reg == LAST)
                    begin
                        unique case (phase_reg)
                            PH_PX:   px_reg[o_reg] <= dot_sat;
                            PH_XPX:  den_reg <= signed'({3'b000, rv_reg}) + (Q_W+2)'(dot_sat);
                            PH_XT:   innov_reg <= sat32(sx32(y_reg) - sx32(dot_sat));
                            PH_XP:   xp_reg[o_reg] <= dot_sat;
                            default: ;
                        endcase
                    end

                    if (n_reg != LAST)
                    begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                    else if ((phase_reg == PH_PX || phase_reg == PH_XP || phase_reg == PH_PU)
                             && o_reg != LAST)
                    begin
                        o_reg     <= o_reg + 1'b1;
                        n_reg     <= '0;
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        o_reg <= '0;
                        n_reg <= '0;
                        unique case (phase_reg)
                            PH_PX:
                            begin
                                phase_reg <= PH_XPX;
                                state_reg <= ST_RD;
                            end
                            PH_XPX:  state_reg <= ST_DIV_GO;
                            PH_XT:
                            begin
                                phase_reg <= PH_TH;
                                state_reg <= ST_RD;
                            end
                            PH_TH:
                            begin
                                phase_reg <= PH_XP;
                                state_reg <= ST_RD;
                            end
                            PH_XP:
                            begin
                                phase_reg <= PH_PU;
                                state_reg <= ST_RD;
                            end
                            default:
                            begin
                                // Shift the new sample into the regressor.
                                for (int k = OUTPUT_ORDER - 1; k > 0; k--)
                                begin
                                    x_reg[k] <= x_reg[k-1];
                                end
                                x_reg[0] <= (y_reg == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -y_reg;
                                for (int k = INPUT_ORDER - 1; k > 0; k--)
                                begin
                                    x_reg[OUTPUT_ORDER+k] <= x_reg[OUTPUT_ORDER+k-1];
                                end
                                x_reg[OUTPUT_ORDER] <= u_reg;
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end

                ST_DIV_GO,
                ST_DIV_WAIT:
                begin
                    // A non-positive denominator forces every gain to zero.
                    if (state_reg == ST_DIV_GO && den_pos)
                    begin
                        state_reg <= ST_DIV_WAIT;
                    end
                    else if (state_reg == ST_DIV_GO || div_done)
                    begin
                        gain_reg[n_reg] <= (state_reg == ST_DIV_GO) ? '0 : div_quot;
                        if (n_reg == LAST)
                        begin
                            n_reg     <= '0;
                            phase_reg <= PH_XT;
                            state_reg <= ST_RD;
                        end
                        else
                        begin
                            n_reg     <= n_reg + 1'b1;
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end

                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_data_reg.estimate_a1 <= est_c[0];
                        out_data_reg.estimate_a2 <= est_c[1];
                        out_data_reg.estimate_b1 <= est_c[2];
                        out_data_reg.estimate_b2 <= est_c[3];
                        state_reg                <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: verif/tb_kalman_arx_parameter_estimator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for kalman_arx_parameter_estimator_core.
// Depends on kaest_pkg and the core; a built-in predictor computes the expected estimates.
module tb_kalman_arx_parameter_estimator_core;
    import kaest_pkg::*;

    localparam int NT = 4;
    localparam int LATENCY = 600;
    localparam longint CYCLE_LIMIT = 5000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kalman_arx_parameter_estimator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state, kept as wide signed values so that every intermediate sum is exact.
    longint mdl_noise_var;
    longint mdl_proc_noise [NT];
    longint mdl_cov [NT][NT];
    longint mdl_theta [NT];
    longint mdl_regr [NT];

    in_item_t request_queue [$];
    out_item_t estimate_queue [$];
    int error_count;
    int requests_sent;
    int estimates_seen;
    longint cycle_count;

    // Clock with a 4 ns period.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q8.24 product, rounded half up; the arithmetic shift gives the floor.
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + 64'sd8388608) >>> 24;
    endfunction

    // Q8.24 division, rounded to nearest with ties away from zero, then saturated.
    function automatic longint qdiv(input longint num, input longint den);
        longint n;
        longint mag;
        longint q;
        n = num * 64'sd16777216;
        mag = (n < 0) ? -n : n;
        q = (mag + den / 2) / den;
        return clamp32((n < 0) ? -q : q);
    endfunction

    function automatic void predictor_reset();
        mdl_noise_var = 16777216;
        for (int i = 0; i < NT; i++)
        begin
            mdl_proc_noise[i] = 0;
            mdl_theta[i] = theta_init(i);
            mdl_regr[i] = 0;
            for (int j = 0; j < NT; j++)
                mdl_cov[i][j] = (i == j) ? 1678 : 0;
        end
    endfunction

    // One Kalman update for a request; mdl_cov[i][j] is row i, column j.
    function automatic out_item_t predict_estimates(input in_item_t req);
        longint px [NT];
        longint gain [NT];
        longint xp [NT];
        longint acc;
        longint den;
        longint innov;
        longint y;
        out_item_t res;
        y = req.plant_output;
        for (int i = 0; i < NT; i++)
            mdl_cov[i][i] = clamp32(mdl_cov[i][i] + mdl_proc_noise[i]);
        for (int i = 0; i < NT; i++)
        begin
            acc = 0;
            for (int j = 0; j < NT; j++)
                acc += qmul(mdl_cov[i][j], mdl_regr[j]);
            px[i] = clamp32(acc);
        end
        acc = 0;
        for (int i = 0; i < NT; i++)
            acc += qmul(mdl_regr[i], px[i]);
        den = mdl_noise_var + clamp32(acc);
        // A denominator that is not positive switches the update off entirely.
        for (int i = 0; i < NT; i++)
            gain[i] = (den > 0) ? qdiv(px[i], den) : 0;
        acc = 0;
        for (int i = 0; i < NT; i++)
            acc += qmul(mdl_regr[i], mdl_theta[i]);
        innov = clamp32(y - clamp32(acc));
        for (int i = 0; i < NT; i++)
            mdl_theta[i] = clamp32(mdl_theta[i] + qmul(gain[i], innov));
        for (int j = 0; j < NT; j++)
        begin
            acc = 0;
            for (int i = 0; i < NT; i++)
                acc += qmul(mdl_regr[i], mdl_cov[i][j]);
            xp[j] = clamp32(acc);
        end
        for (int j = 0; j < NT; j++)
            for (int i = 0; i < NT; i++)
                mdl_cov[i][j] = clamp32(mdl_cov[i][j] - qmul(gain[i], xp[j]));
        // Regressor shift; negating the most negative output saturates.
        mdl_regr[1] = mdl_regr[0];
        mdl_regr[0] = clamp32(-y);
        mdl_regr[3] = mdl_regr[2];
        mdl_regr[2] = req.plant_input;
        res.estimate_a1 = mdl_theta[0][31:0];
        res.estimate_a2 = mdl_theta[1][31:0];
        res.estimate_b1 = mdl_theta[2][31:0];
        res.estimate_b2 = mdl_theta[3][31:0];
        return res;
    endfunction

    // Request driver: changes on the falling edge, with a random gap before each request.
    // A request is still waiting while fewer requests have been taken than issued.
    int send_gap;
    int requests_issued;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
            requests_issued <= 0;
        end
        else if (in_valid && requests_sent != requests_issued)
        begin
            // Hold the request until it is taken.
        end
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (request_queue.size() > 0 && !in_valid)
        begin
            in_data <= request_queue.pop_front();
            in_valid <= 1'b1;
            requests_issued <= requests_issued + 1;
        end
        else
        begin
            // The request just taken ends here, and the next one waits out a fresh gap.
            in_valid <= 1'b0;
            send_gap <= $urandom_range(0, 6);
        end
    end

    // Acceptance on the rising edge drives the predictor.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            estimate_queue.push_back(predict_estimates(in_data));
            requests_sent <= requests_sent + 1;
        end
    end

    // Result monitor, with out_ready stalled at random from the falling edge.
    int stall_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (out_ready && out_valid)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            estimates_seen <= estimates_seen + 1;
            if (estimate_queue.size() == 0)
            begin
                $display("%0t: unexpected estimate set %h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = estimate_queue.pop_front();
                if (want.estimate_a1 !== out_data.estimate_a1)
                begin
                    $display("%0t: estimate_a1 expected %0d actual %0d", $time,
                             want.estimate_a1, out_data.estimate_a1);
                    error_count++;
                end
                if (want.estimate_a2 !== out_data.estimate_a2)
                begin
                    $display("%0t: estimate_a2 expected %0d actual %0d", $time,
                             want.estimate_a2, out_data.estimate_a2);
                    error_count++;
                end
                if (want.estimate_b1 !== out_data.estimate_b1)
                begin
                    $display("%0t: estimate_b1 expected %0d actual %0d", $time,
                             want.estimate_b1, out_data.estimate_b1);
                    error_count++;
                end
                if (want.estimate_b2 !== out_data.estimate_b2)
                begin
                    $display("%0t: estimate_b2 expected %0d actual %0d", $time,
                             want.estimate_b2, out_data.estimate_b2);
                    error_count++;
                end
            end
        end
    end

    // Register write on the falling edge; the predictor copy is updated alongside.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_RV)
            mdl_noise_var = val;
        else
            mdl_proc_noise[idx - REG_Q0] = val;
    endtask

    // Waits until every request has been sent and answered, then lets the core settle.
    task automatic drain();
        while (request_queue.size() > 0 || in_valid || estimate_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_sample(input int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2 * 16777216)) - 32'sd16777216;
            default: return $signed($urandom_range(0, 1 << 22)) - 32'sd2097152;
        endcase
    endfunction

    task automatic queue_random(input int n, input int style);
        in_item_t r;
        for (int i = 0; i < n; i++)
        begin
            // Mostly the chosen scale, with the odd full-range sample mixed in.
            r.plant_output = ($urandom_range(0, 15) == 0) ? $urandom : rand_sample(style);
            r.plant_input = ($urandom_range(0, 15) == 0) ? $urandom : rand_sample(style);
            request_queue.push_back(r);
        end
    endtask

    task automatic queue_pair(input logic signed [31:0] y, input logic signed [31:0] u);
        in_item_t r;
        r.plant_output = y;
        r.plant_input = u;
        request_queue.push_back(r);
    endtask

    initial
    begin
        error_count = 0;
        requests_sent = 0;
        estimates_seen = 0;
        cycle_count = 0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        predictor_reset();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under reset settings: extremes, including the most negative output.
        queue_pair(32'sd0, 32'sd0);
        queue_pair(32'sd16777216, -32'sd16777216);
        queue_pair(32'sh8000_0000, 32'sh7FFF_FFFF);
        queue_pair(32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_pair(32'sh8000_0000, 32'sh8000_0000);
        queue_pair(-32'sd1, 32'sd1);
        queue_pair(32'sh5555_5555, 32'shAAAA_AAAA);
        queue_pair(32'shAAAA_AAAA, 32'sh5555_5555);
        queue_pair(32'sd8388608, 32'sd4194304);
        queue_pair(32'sd0, 32'sd0);
        drain();

        // Large process noise and the smallest nonzero measurement noise drive saturation.
        write_reg(REG_RV, 31'd1);
        write_reg(REG_Q0, 31'h7FFF_FFFF);
        write_reg(REG_Q1, 31'h7FFF_FFFF);
        write_reg(REG_Q2, 31'h7FFF_FFFF);
        write_reg(REG_Q3, 31'h7FFF_FFFF);
        queue_pair(32'sd16777216, 32'sd16777216);
        queue_pair(-32'sd16777216, 32'sd33554432);
        queue_pair(32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_pair(32'sd1, -32'sd1);
        drain();

        // Largest measurement noise with no process noise.
        write_reg(REG_RV, 31'h7FFF_FFFF);
        write_reg(REG_Q0, 31'd0);
        write_reg(REG_Q1, 31'd0);
        write_reg(REG_Q2, 31'd0);
        write_reg(REG_Q3, 31'd0);
        queue_random(8, 1);
        drain();

        // Random phases, each under new settings; small and moderate scales dominate.
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_RV, (ph % 4 == 0) ? 31'd16777216 : 31'($urandom_range(1, 1 << 26)));
            write_reg(REG_Q0, 31'($urandom_range(0, 1 << 16)));
            write_reg(REG_Q1, 31'($urandom_range(0, 1 << 16)));
            write_reg(REG_Q2, (ph == 5) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 1 << 16)));
            write_reg(REG_Q3, 31'($urandom_range(0, 1 << 20)));
            queue_random(150, ph % 3);
            drain();
        end

        $display("Covered %0d requests and %0d estimate sets over 15 register settings,",
                 requests_sent, estimates_seen);
        $display("including extreme samples and extreme noise values.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
